// ===== rtl/rgch_pkg.sv =====
// Package with the shared types and constants of the rg-chromaticity histogram unit.
`timescale 1ns / 1ps

package rgch_pkg;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int HALF_W  = 11;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 24;
  localparam int SUM_W   = 10;

  localparam logic [1:0] REG_IMAGE_ROWS  = 2'd0;
  localparam logic [1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [1:0] REG_CENTER_ONLY = 2'd2;
  localparam logic [1:0] REG_WINDOW_HALF = 2'd3;

  localparam logic [COORD_W-1:0] IMAGE_ROWS_RESET  = 12'd480;
  localparam logic [COORD_W-1:0] IMAGE_COLS_RESET  = 12'd640;
  localparam logic [HALF_W-1:0]  WINDOW_HALF_RESET = 11'd50;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/rg_chromaticity_histogram_unit.sv =====
// Top level of the rg-chromaticity histogram unit: bin store, divider and control.
`timescale 1ns / 1ps

// Each word on the input either accumulates one pixel into the BINS x BINS
// histogram or reads and clears one bin, and gives exactly one result word.
// A pixel word passes through the bit-serial divider, which forms both
// chromaticity indices at one quotient bit a cycle, and then a read and a
// write-back on the bin memory; a read word goes straight to the read and
// write-back. No new word is taken until the last one is through. After
// reset the bin memory is cleared one entry a cycle, and the input stalls
// until all BINS*BINS entries are cleared, while configuration writes are
// taken throughout. A finished result waits in the output register; a
// further result waits in the update state until that register is free.
module rg_chromaticity_histogram_unit #(
  parameter int BINS        = 16,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgch_pkg::ADDR_W-1:0]   paddr,
  input  logic [rgch_pkg::DATA_W-1:0]   pwdata,
  output logic [rgch_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [rgch_pkg::PIX_W-1:0]    red,
  input  logic [rgch_pkg::PIX_W-1:0]    green,
  input  logic [rgch_pkg::PIX_W-1:0]    blue,
  input  logic [rgch_pkg::COORD_W-1:0]  pixel_row,
  input  logic [rgch_pkg::COORD_W-1:0]  pixel_col,
  input  logic [rgch_pkg::INDEX_W-1:0]  read_bin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          counted,
  output logic [rgch_pkg::INDEX_W-1:0]  bin_index,
  output logic [rgch_pkg::COUNT_W-1:0]  bin_count
);
  import rgch_pkg::*;

  localparam int NUM_BINS = BINS * BINS;
  localparam int AW       = $clog2(NUM_BINS);
  localparam int BW       = $clog2(BINS);
  localparam int QW       = BW + 1;
  localparam int DW       = SUM_W + QW;
  localparam int CNTW     = $clog2(QW);
  localparam int NW       = $clog2(NUM_BINS + 1) + INDEX_W;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  state_t state;
  state_t state_next;

  logic [COORD_W-1:0] image_rows;
  logic [COORD_W-1:0] image_cols;
  logic               center_only;
  logic [HALF_W-1:0]  window_half;

  logic               item_op;
  logic [SUM_W-1:0]   item_sum;
  logic [COORD_W-1:0] item_row;
  logic [COORD_W-1:0] item_col;
  logic [INDEX_W-1:0] item_rd;

  logic [DW-1:0]      rem_r;
  logic [DW-1:0]      rem_g;
  logic [DW-1:0]      divisor;
  logic [QW-1:0]      quot_r;
  logic [QW-1:0]      quot_g;
  logic [CNTW-1:0]    div_cnt;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] mem_rdata;
  logic [AW-1:0]          clr_addr;

  logic               in_accept;
  logic               cfg_write;
  logic               slot_free;
  logic               div_step;
  logic               mem_re;
  logic               mem_we;
  logic               out_load;
  logic [AW-1:0]      mem_addr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  logic [SUM_W-1:0]   in_sum;
  logic               ge_r;
  logic               ge_g;
  logic [BW-1:0]      idx_r;
  logic [BW-1:0]      idx_g;
  logic [AW-1:0]      pix_addr;
  logic [AW-1:0]      rd_addr;
  logic [AW+INDEX_W-1:0] rd_wide;
  logic [AW+INDEX_W-1:0] pix_wide;
  logic               rd_ok;
  logic [HALF_W-1:0]  mid_rows;
  logic [HALF_W-1:0]  mid_cols;
  logic               row_in_win;
  logic               col_in_win;
  logic               take;
  logic               bump;
  logic [INDEX_W-1:0] res_index;
  logic [COUNT_WIDTH-1:0] res_count;
  logic [COUNT_WIDTH+COUNT_W-1:0] count_wide;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= IMAGE_ROWS_RESET;
      image_cols  <= IMAGE_COLS_RESET;
      center_only <= 1'b0;
      window_half <= WINDOW_HALF_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_IMAGE_ROWS:  image_rows  <= pwdata[COORD_W-1:0];
        REG_IMAGE_COLS:  image_cols  <= pwdata[COORD_W-1:0];
        REG_CENTER_ONLY: center_only <= pwdata[0];
        REG_WINDOW_HALF: window_half <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_ROWS:  prdata = {{(DATA_W-COORD_W){1'b0}}, image_rows};
      REG_IMAGE_COLS:  prdata = {{(DATA_W-COORD_W){1'b0}}, image_cols};
      REG_CENTER_ONLY: prdata = {{(DATA_W-1){1'b0}}, center_only};
      REG_WINDOW_HALF: prdata = {{(DATA_W-HALF_W){1'b0}}, window_half};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(NUM_BINS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (operation == OP_READ) ? ST_READ : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    div_step = 1'b0;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_CLEAR:  mem_we = 1'b1;
      ST_IDLE:   in_stall = 1'b0;
      ST_DIV:    div_step = 1'b1;
      ST_READ:   mem_re = 1'b1;
      ST_UPDATE: begin
        out_load = slot_free;
        mem_we   = slot_free && (((item_op == OP_READ) && rd_ok) || bump);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign in_sum = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_op  <= operation;
      item_sum <= in_sum;
      item_row <= pixel_row;
      item_col <= pixel_col;
      item_rd  <= read_bin;
    end
  end

  assign ge_r = rem_r >= divisor;
  assign ge_g = rem_g >= divisor;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rem_r   <= DW'(red) * DW'(BINS);
      rem_g   <= DW'(green) * DW'(BINS);
      divisor <= DW'(in_sum) << (QW - 1);
      quot_r  <= '0;
      quot_g  <= '0;
      div_cnt <= CNTW'(QW - 1);
    end else if (div_step) begin
      rem_r   <= ge_r ? rem_r - divisor : rem_r;
      rem_g   <= ge_g ? rem_g - divisor : rem_g;
      divisor <= divisor >> 1;
      quot_r  <= {quot_r[QW-2:0], ge_r};
      quot_g  <= {quot_g[QW-2:0], ge_g};
      div_cnt <= div_cnt - CNTW'(1);
    end
  end

  assign idx_r    = (quot_r > QW'(BINS - 1)) ? BW'(BINS - 1) : quot_r[BW-1:0];
  assign idx_g    = (quot_g > QW'(BINS - 1)) ? BW'(BINS - 1) : quot_g[BW-1:0];
  assign pix_addr = AW'(idx_r) * AW'(BINS) + AW'(idx_g);

  assign rd_wide  = {{AW{1'b0}}, item_rd};
  assign rd_addr  = rd_wide[AW-1:0];
  assign rd_ok    = {{(NW-INDEX_W){1'b0}}, item_rd} < NW'(NUM_BINS);
  assign pix_wide = {{INDEX_W{1'b0}}, pix_addr};

  assign mid_rows   = image_rows[COORD_W-1:1];
  assign mid_cols   = image_cols[COORD_W-1:1];
  assign row_in_win = ((window_half > mid_rows) ||
                       (item_row >= COORD_W'(mid_rows - window_half))) &&
                      ((COORD_W + 1)'(item_row) <
                       (COORD_W + 1)'(mid_rows) + (COORD_W + 1)'(window_half));
  assign col_in_win = ((window_half > mid_cols) ||
                       (item_col >= COORD_W'(mid_cols - window_half))) &&
                      ((COORD_W + 1)'(item_col) <
                       (COORD_W + 1)'(mid_cols) + (COORD_W + 1)'(window_half));

  assign take = (item_sum != '0) && (item_row < image_rows) && (item_col < image_cols) &&
                (!center_only || (row_in_win && col_in_win));
  assign bump = (item_op == OP_ACCUM) && take && (mem_rdata != COUNT_MAX);

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (item_op == OP_READ) begin
      mem_addr  = rd_addr;
      mem_wdata = '0;
    end else begin
      mem_addr  = pix_addr;
      mem_wdata = mem_rdata + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  always_comb begin
    if (item_op == OP_READ) begin
      res_index = item_rd;
      res_count = rd_ok ? mem_rdata : '0;
    end else begin
      res_index = take ? pix_wide[INDEX_W-1:0] : '0;
      res_count = '0;
    end
  end

  assign count_wide = {{COUNT_W{1'b0}}, res_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      counted   <= bump;
      bin_index <= res_index;
      bin_count <= count_wide[COUNT_W-1:0];
    end
  end

endmodule

// ===== tb/rg_chromaticity_histogram_unit_test.sv =====
// Self-checking testbench of the rg-chromaticity histogram unit, with its own histogram predictor.
`timescale 1ns / 1ps

module rg_chromaticity_histogram_unit_test;
  import rgch_pkg::*;

  localparam int BINS = 16;
  localparam int NUM_BINS = BINS * BINS;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic                op;
    logic [PIX_W-1:0]    r;
    logic [PIX_W-1:0]    g;
    logic [PIX_W-1:0]    b;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [INDEX_W-1:0]  rd_bin;
  } pixel_word_t;

  typedef struct packed {
    logic                counted;
    logic [INDEX_W-1:0]  bin;
    logic [COUNT_W-1:0]  tally;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_ACCUM;
  logic [PIX_W-1:0] red = '0;
  logic [PIX_W-1:0] green = '0;
  logic [PIX_W-1:0] blue = '0;
  logic [COORD_W-1:0] pixel_row = '0;
  logic [COORD_W-1:0] pixel_col = '0;
  logic [INDEX_W-1:0] read_bin = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic counted;
  logic [INDEX_W-1:0] bin_index;
  logic [COUNT_W-1:0] bin_count;

  rg_chromaticity_histogram_unit #(
    .BINS(BINS),
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .red(red), .green(green), .blue(blue),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .read_bin(read_bin),
    .out_valid(out_valid), .out_stall(out_stall),
    .counted(counted), .bin_index(bin_index), .bin_count(bin_count)
  );

  always #2 clk = ~clk;

  logic [COORD_W-1:0] rows_cfg = IMAGE_ROWS_RESET;
  logic [COORD_W-1:0] cols_cfg = IMAGE_COLS_RESET;
  logic center_cfg = 1'b0;
  logic [HALF_W-1:0] half_cfg = WINDOW_HALF_RESET;
  logic [COUNT_W-1:0] bin_tally [NUM_BINS] = '{default: '0};
  logic [3*PIX_W-1:0] palette [6];

  pixel_word_t words_to_send [$];
  bin_result_t bin_results_due [$];
  pixel_word_t offered_word;
  bin_result_t awaited;
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned error_count = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  function automatic logic [INDEX_W-1:0] chroma_bin(input logic [PIX_W-1:0] r, g, b);
    int unsigned total, ri, gi;
    total = r + g + b;
    ri = (r * BINS) / total;
    gi = (g * BINS) / total;
    if (ri > BINS - 1) ri = BINS - 1;
    if (gi > BINS - 1) gi = BINS - 1;
    return INDEX_W'(ri * BINS + gi);
  endfunction

  function automatic bit in_window(input int unsigned pos, input int unsigned size);
    int mid, lo, hi;
    mid = int'(size / 2);
    lo = mid - int'(half_cfg);
    hi = mid + int'(half_cfg);
    return int'(pos) >= lo && int'(pos) < hi;
  endfunction

  function automatic bin_result_t histogram_update(input pixel_word_t w);
    bin_result_t res;
    bit take;
    logic [INDEX_W-1:0] addr;
    res = '0;
    if (w.op == OP_READ) begin
      res.bin = w.rd_bin;
      res.tally = bin_tally[w.rd_bin];
      bin_tally[w.rd_bin] = '0;
    end else begin
      take = (w.r | w.g | w.b) != '0 && w.row < rows_cfg && w.col < cols_cfg;
      if (take && center_cfg) take = in_window(w.row, rows_cfg) && in_window(w.col, cols_cfg);
      if (take) begin
        addr = chroma_bin(w.r, w.g, w.b);
        res.bin = addr;
        if (bin_tally[addr] != COUNT_MAX) begin
          bin_tally[addr]++;
          res.counted = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned size);
    int lo, hi;
    lo = int'(size / 2) - int'(half_cfg) - 1;
    hi = int'(size / 2) + int'(half_cfg);
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    case ($urandom_range(0, 9))
      0, 1, 2: return COORD_W'($urandom_range(0, 4095));
      3, 4, 5: return COORD_W'($urandom_range(0, size));
      default: return COORD_W'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic pixel_word_t random_word();
    pixel_word_t w;
    logic [3*PIX_W-1:0] colour;
    int unsigned pick;
    w.op = OP_ACCUM;
    w.r = PIX_W'($urandom);
    w.g = PIX_W'($urandom);
    w.b = PIX_W'($urandom);
    w.row = COORD_W'($urandom);
    w.col = COORD_W'($urandom);
    w.rd_bin = INDEX_W'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      w.op = OP_READ;
      if ($urandom_range(0, 1) == 1) begin
        colour = palette[$urandom_range(0, 5)];
        w.rd_bin = chroma_bin(colour[23:16], colour[15:8], colour[7:0]);
      end
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        {w.r, w.g, w.b} = palette[$urandom_range(0, 5)];
      end else if (pick == 6) begin
        {w.r, w.g, w.b} = '0;
        case ($urandom_range(0, 3))
          1: w.r = PIX_W'($urandom);
          2: w.g = PIX_W'($urandom);
          3: w.b = PIX_W'($urandom);
          default: ;
        endcase
      end
      w.row = pick_coord(rows_cfg);
      w.col = pick_coord(cols_cfg);
    end
    return w;
  endfunction

  task automatic queue_word(input pixel_word_t w);
    words_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic add_pixel(input logic [PIX_W-1:0] r, g, b,
                           input logic [COORD_W-1:0] row, col);
    queue_word('{op: OP_ACCUM, r: r, g: g, b: b, row: row, col: col, rd_bin: '0});
  endtask

  task automatic add_read(input logic [INDEX_W-1:0] bin);
    queue_word('{op: OP_READ, r: '0, g: '0, b: '0, row: '0, col: '0, rd_bin: bin});
  endtask

  task automatic fill_random(input int unsigned n);
    for (int i = 0; i < 6; i++) palette[i] = 24'($urandom_range(1, 24'hFFFFFF));
    repeat (n) queue_word(random_word());
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || bin_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] sel, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      REG_IMAGE_ROWS: rows_cfg = value[COORD_W-1:0];
      REG_IMAGE_COLS: cols_cfg = value[COORD_W-1:0];
      REG_CENTER_ONLY: center_cfg = value[0];
      default: half_cfg = value[HALF_W-1:0];
    endcase
  endtask

  task automatic configure_image(input int unsigned rows, cols, center, half);
    write_register(REG_IMAGE_ROWS, rows);
    write_register(REG_IMAGE_COLS, cols);
    write_register(REG_CENTER_ONLY, center);
    write_register(REG_WINDOW_HALF, half);
  endtask

  // Each accepted word is run through the predictor at the edge that takes it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bin_results_due.push_back(histogram_update(offered_word));
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          offered_word = words_to_send.pop_front();
          operation <= offered_word.op;
          red <= offered_word.r;
          green <= offered_word.g;
          blue <= offered_word.b;
          pixel_row <= offered_word.row;
          pixel_col <= offered_word.col;
          read_bin <= offered_word.rd_bin;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver changes its stall pattern now and then, and once holds off for a long stretch.
  int unsigned stall_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle++;
      if (stall_cycle == 1000) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (bin_results_due.size() == 0) begin
        report_mismatch($sformatf("result word with none expected (bin %0d)", bin_index));
      end else begin
        awaited = bin_results_due.pop_front();
        if (counted !== awaited.counted)
          report_mismatch($sformatf("counted %b, expected %b", counted, awaited.counted));
        if (bin_index !== awaited.bin)
          report_mismatch($sformatf("bin_index %0d, expected %0d", bin_index, awaited.bin));
        if (bin_count !== awaited.tally)
          report_mismatch($sformatf("bin_count %0d, expected %0d", bin_count, awaited.tally));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_pixel(8'd0, 8'd0, 8'd0, 12'd10, 12'd10);
    add_pixel(8'd255, 8'd0, 8'd0, 12'd0, 12'd0);
    add_pixel(8'd0, 8'd255, 8'd0, 12'd479, 12'd639);
    add_pixel(8'd0, 8'd0, 8'd255, 12'd480, 12'd0);
    add_pixel(8'd0, 8'd0, 8'd255, 12'd0, 12'd640);
    add_pixel(8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095);
    add_pixel(8'd255, 8'd255, 8'd255, 12'd100, 12'd100);
    add_pixel(8'd1, 8'd0, 8'd0, 12'd1, 12'd1);
    add_pixel(8'd1, 8'd1, 8'd1, 12'd2, 12'd2);
    add_pixel(8'd0, 8'd0, 8'd1, 12'd3, 12'd3);
    add_read(8'd240);
    add_read(8'd240);
    add_read(8'd0);
    add_read(8'd255);
    add_read(8'hAA);
    add_read(8'd85);
    add_read(8'd15);
    wait_drained();

    configure_image(480, 640, 1, 50);
    add_pixel(8'd200, 8'd30, 8'd10, 12'd189, 12'd320);
    add_pixel(8'd200, 8'd30, 8'd10, 12'd190, 12'd320);
    add_pixel(8'd200, 8'd30, 8'd10, 12'd289, 12'd320);
    add_pixel(8'd200, 8'd30, 8'd10, 12'd290, 12'd320);
    add_pixel(8'd200, 8'd30, 8'd10, 12'd240, 12'd269);
    add_pixel(8'd200, 8'd30, 8'd10, 12'd240, 12'd369);
    add_pixel(8'd200, 8'd30, 8'd10, 12'd240, 12'd370);
    fill_random(300);
    wait_drained();

    configure_image(1, 1, 1, 1);
    fill_random(150);
    wait_drained();

    configure_image(4095, 4095, 0, 2047);
    fill_random(300);
    wait_drained();

    configure_image(37, 4095, 1, 2047);
    fill_random(300);
    wait_drained();

    configure_image($urandom_range(1, 4095), $urandom_range(1, 4095),
                    $urandom_range(0, 1), $urandom_range(1, 2047));
    fill_random(200);
    for (int i = 0; i < NUM_BINS; i++) add_read(INDEX_W'(i));
    wait_drained();

    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rgch_pkg.sv
rtl/rg_chromaticity_histogram_unit.sv
tb/rg_chromaticity_histogram_unit_test.sv
